// ===== src/go_to_goal_heading_controller_defines.svh =====
// Assertion macros for the go-to-goal heading controller.
`ifndef GO_TO_GOAL_HEADING_CONTROLLER_DEFINES_SVH
`define GO_TO_GOAL_HEADING_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define G2G_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("g2g: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define G2G_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("g2g: next-cycle check failed");

`endif

// ===== src/g2g_pkg.sv =====
// Types, constants and the CORDIC angle table of the heading controller.
package g2g_pkg;

  // CORDIC depth and datapath width (vector magnitude stays below 2^34)
  localparam int unsigned CORDIC_STAGES = 16;
  localparam int unsigned CORDIC_W      = 36;

  // round(pi * 2^29)
  localparam logic [30:0] PI_Q29 = 31'd1686629713;

  // Register reset values
  localparam logic [15:0] HEADING_GAIN_RST = 16'd2048;
  localparam logic [31:0] CRUISE_SPEED_RST = 32'd32768;
  localparam logic [30:0] STOP_OFFSET_RST  = 31'd19661;

  typedef enum logic [1:0] {
    CFG_HEADING_GAIN = 2'd0,
    CFG_CRUISE_SPEED = 2'd1,
    CFG_STOP_OFFSET  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [15:0] robot_heading;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] linear_speed;
    logic signed [31:0] angular_rate;
    logic               stopped;
  } out_t;

  // One CORDIC stage: vector, angle and the sideband that rides along
  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic [31:0]                z;
    logic signed [15:0]         hd;
    logic                       stop;
    logic                       zero;
  } cord_t;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] a;
    case (idx)
      0:  a = 32'd536870912;
      1:  a = 32'd316933405;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== src/g2g_if.sv =====
// Valid/ready channel interfaces: pose input, command output, register writes.
interface g2g_in_if;
  logic          valid;
  logic          ready;
  g2g_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface g2g_out_if;
  logic          valid;
  logic          ready;
  g2g_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface g2g_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/go_to_goal_heading_controller.sv =====
// Go-to-goal heading controller: pipelined CORDIC bearing and proportional turn rate.
//
//  channel | dir | payload                                         | transaction
//  in_i    | in  | robot_x, robot_y, robot_heading, goal_x, goal_y | valid & ready
//  out_o   | out | linear_speed, angular_rate, stopped             | valid & ready
//  cfg_i   | in  | index (0 gain, 1 cruise speed, 2 stop offset)   | valid & ready
//
// One transaction enters per cycle while no result waits at the output; its result passes
// the difference, fold, one-per-CORDIC-iteration, error, two product and output registers.
// Reset clears every valid bit and loads the register reset values.
// The whole pipeline holds while a result waits at the output; cfg_i is always ready.
`include "go_to_goal_heading_controller_defines.svh"

module go_to_goal_heading_controller (
  input  logic    clk_i,
  input  logic    rst_ni,
  g2g_in_if.sink  in_i,
  g2g_out_if.source out_o,
  g2g_cfg_if.sink cfg_i
);

  localparam int unsigned N = g2g_pkg::CORDIC_STAGES;
  localparam int unsigned W = g2g_pkg::CORDIC_W;

  // Configuration registers
  logic [15:0] gain_q;
  logic [31:0] cruise_q;
  logic [30:0] stop_off_q;

  // Pipeline advance
  logic en;

  // Difference stage
  logic               d_v_q;
  logic signed [32:0] dx_q, dy_q;
  logic signed [15:0] d_hd_q;

  // CORDIC stages (index 0 is the fold stage)
  logic [N:0]      c_v_q;
  g2g_pkg::cord_t  c_q [N+1];
  g2g_pkg::cord_t  c_d [N];
  g2g_pkg::cord_t  fold_d;

  // Error, product and output stages
  logic               e_v_q, e_stop_q;
  logic signed [15:0] e_q;
  logic               m1_v_q, m1_stop_q;
  logic signed [32:0] gm_q;
  logic               m2_v_q, m2_stop_q;
  logic signed [63:0] p_q;
  logic               out_v_q;
  g2g_pkg::out_t      out_q;

  logic signed [15:0] e_d;
  logic [31:0]        zr;
  logic signed [32:0] gm_d;
  logic signed [63:0] p_d;
  logic signed [63:0] r_d;
  g2g_pkg::out_t      out_d;

  assign en          = !out_v_q || out_o.ready;
  assign in_i.ready  = en;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  // Take register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= g2g_pkg::HEADING_GAIN_RST;
      cruise_q   <= g2g_pkg::CRUISE_SPEED_RST;
      stop_off_q <= g2g_pkg::STOP_OFFSET_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        g2g_pkg::CFG_HEADING_GAIN: gain_q     <= cfg_i.data[15:0];
        g2g_pkg::CFG_CRUISE_SPEED: cruise_q   <= cfg_i.data;
        g2g_pkg::CFG_STOP_OFFSET:  stop_off_q <= cfg_i.data[30:0];
        default: ;
      endcase
    end
  end

  // Fold stage: stop test, zero test, move the vector into the right half plane
  always_comb begin
    logic signed [33:0] ndx, ndy;
    logic [32:0]        adx, ady;
    logic signed [W-1:0] dxw, dyw;
    ndx = -{dx_q[32], dx_q};
    ndy = -{dy_q[32], dy_q};
    adx = dx_q[32] ? ndx[32:0] : dx_q;
    ady = dy_q[32] ? ndy[32:0] : dy_q;
    dxw = {{(W-33){dx_q[32]}}, dx_q};
    dyw = {{(W-33){dy_q[32]}}, dy_q};
    fold_d.stop = (adx < {2'b00, stop_off_q}) && (ady < {2'b00, stop_off_q});
    fold_d.zero = (dx_q == '0) && (dy_q == '0);
    fold_d.hd   = d_hd_q;
    if (dx_q[32]) begin
      fold_d.x = -dxw;
      fold_d.y = -dyw;
      fold_d.z = 32'h8000_0000;
    end else begin
      fold_d.x = dxw;
      fold_d.y = dyw;
      fold_d.z = 32'h0;
    end
  end

  // One vectoring rotation per stage, constant shifts
  always_comb begin
    for (int unsigned k = 0; k < N; k++) begin
      c_d[k] = c_q[k];
      if (!c_q[k].y[W-1]) begin
        c_d[k].x = c_q[k].x + (c_q[k].y >>> k);
        c_d[k].y = c_q[k].y - (c_q[k].x >>> k);
        c_d[k].z = c_q[k].z + g2g_pkg::atan_turn(k);
      end else begin
        c_d[k].x = c_q[k].x - (c_q[k].y >>> k);
        c_d[k].y = c_q[k].y + (c_q[k].x >>> k);
        c_d[k].z = c_q[k].z - g2g_pkg::atan_turn(k);
      end
    end
  end

  // Round bearing to 16 bits and wrap the heading error
  always_comb begin
    zr  = c_q[N].zero ? 32'h0 : (c_q[N].z + 32'h0000_8000);
    e_d = zr[31:16] - c_q[N].hd;
  end

  // Gain times error, then times pi
  assign gm_d = $signed({1'b0, gain_q}) * e_q;
  assign p_d  = gm_q * $signed({1'b0, g2g_pkg::PI_Q29});

  // Round half up to Q16.16; result stays well inside 32 bits
  always_comb begin
    r_d = (p_q + (64'sd1 <<< 39)) >>> 40;
    out_d.stopped      = m2_stop_q;
    out_d.linear_speed = m2_stop_q ? 32'sd0 : $signed(cruise_q);
    out_d.angular_rate = m2_stop_q ? 32'sd0 : r_d[31:0];
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q   <= 1'b0;
      c_v_q   <= '0;
      e_v_q   <= 1'b0;
      m1_v_q  <= 1'b0;
      m2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      d_v_q   <= in_i.valid;
      c_v_q   <= {c_v_q[N-1:0], d_v_q};
      e_v_q   <= c_v_q[N];
      m1_v_q  <= e_v_q;
      m2_v_q  <= m1_v_q;
      out_v_q <= m2_v_q;
    end
  end

  // Payload registers advance with the valid bits
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q      <= {in_i.data.goal_x[31], in_i.data.goal_x}
                 - {in_i.data.robot_x[31], in_i.data.robot_x};
      dy_q      <= {in_i.data.goal_y[31], in_i.data.goal_y}
                 - {in_i.data.robot_y[31], in_i.data.robot_y};
      d_hd_q    <= in_i.data.robot_heading;
      c_q[0]    <= fold_d;
      for (int unsigned k = 0; k < N; k++) begin
        c_q[k+1] <= c_d[k];
      end
      e_q       <= e_d;
      e_stop_q  <= c_q[N].stop;
      gm_q      <= gm_d;
      m1_stop_q <= e_stop_q;
      p_q       <= p_d;
      m2_stop_q <= m1_stop_q;
      out_q     <= out_d;
    end
  end

  // Checks
  `G2G_ASSERT_IMP(a_stop_zero, clk_i, rst_ni, out_v_q && out_q.stopped, out_q.linear_speed == 32'sd0 && out_q.angular_rate == 32'sd0)
  `G2G_ASSERT_IMP(a_cruise_out, clk_i, rst_ni, out_v_q && !out_q.stopped, out_q.linear_speed == $signed(cruise_q))
  `G2G_ASSERT_NXT(a_cordic_exit, clk_i, rst_ni, c_v_q[N] && en, e_v_q)

endmodule
